>>> rtl/rrts_pkg.sv
// Shared types and constants for the round-robin task pool scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int ACTION_W          = 2;
  localparam int CPU_W             = 3;
  localparam int STATUS_W          = 2;
  localparam int DEF_MAX_TASKS     = 32;
  localparam int DEF_NUM_CPUS      = 8;
  localparam int DEF_TASK_ID_WIDTH = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE   = 2'd0,
    ACT_TEARDOWN = 2'd1,
    ACT_SCHEDULE = 2'd2,
    ACT_RELEASE  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_IDLE      = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    append;
    logic    mod_start;
    logic    mod_step;
    logic    scan_start;
    logic    scan_run;
    logic    fetch_last;
    logic    claim;
    logic    sched_idle;
    logic    free_own;
    logic    move;
    logic    finish;
    status_t fin_status;
    logic    fin_pick;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t act;
    logic    full;
    logic    empty;
    logic    cpu_ok;
    logic    rel_skip;
    logic    mod_last;
    logic    hit;
    logic    exhausted;
  } dp_stat_t;

endpackage

>>> rtl/rrts_ctrl.sv
// Sequencing state machine for the task pool scheduler.
`timescale 1ns / 1ps

module rrts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rrts_pkg::dp_stat_t stat,
  output rrts_pkg::dp_cmd_t  cmd
);
  import rrts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_MOD    = 6'b000100,
    S_PREP   = 6'b001000,
    S_SCAN   = 6'b010000,
    S_MOVE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.act)
          ACT_CREATE: begin
            cmd.finish = 1'b1;
            if (stat.full) begin
              cmd.fin_status = ST_FULL;
            end else begin
              cmd.append     = 1'b1;
              cmd.fin_status = ST_OK;
            end
            state_next = S_IDLE;
          end
          ACT_TEARDOWN: begin
            if (stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_NOT_FOUND;
              state_next     = S_IDLE;
            end else begin
              state_next = S_PREP;
            end
          end
          ACT_SCHEDULE: begin
            if (!stat.cpu_ok || stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_IDLE;
              state_next     = S_IDLE;
            end else begin
              cmd.mod_start = 1'b1;
              state_next    = S_MOD;
            end
          end
          ACT_RELEASE: begin
            if (stat.rel_skip) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_OK;
              state_next     = S_IDLE;
            end else begin
              state_next = S_PREP;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        if (stat.hit) begin
          unique case (stat.act)
            ACT_SCHEDULE: begin
              cmd.claim      = 1'b1;
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_OK;
              cmd.fin_pick   = 1'b1;
              state_next     = S_IDLE;
            end
            ACT_RELEASE: begin
              cmd.free_own   = 1'b1;
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_OK;
              state_next     = S_IDLE;
            end
            ACT_TEARDOWN: begin
              cmd.fetch_last = 1'b1;
              state_next     = S_MOVE;
            end
            default: begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_OK;
              state_next     = S_IDLE;
            end
          endcase
        end else if (stat.exhausted) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
          unique case (stat.act)
            ACT_SCHEDULE: begin
              cmd.sched_idle = 1'b1;
              cmd.fin_status = ST_IDLE;
            end
            ACT_TEARDOWN: cmd.fin_status = ST_NOT_FOUND;
            default:      cmd.fin_status = ST_OK;
          endcase
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_MOVE: begin
        // last entry is on the read port now; drop it into the hole
        cmd.move       = 1'b1;
        cmd.finish     = 1'b1;
        cmd.fin_status = ST_OK;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_finish_single: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !cmd.finish)
    else $error("result transfer issued on consecutive cycles");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_DECODE))
    else $error("request load did not move to decode");

  a_move_after_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> $past(cmd.fetch_last))
    else $error("move state entered without fetching last entry");
`endif

endmodule

>>> rtl/rrts_datapath.sv
// Pool memory, per-CPU records, scan engine and start-slot remainder unit.
`timescale 1ns / 1ps

module rrts_datapath #(
  parameter int MAX_TASKS     = rrts_pkg::DEF_MAX_TASKS,
  parameter int NUM_CPUS      = rrts_pkg::DEF_NUM_CPUS,
  parameter int TASK_ID_WIDTH = rrts_pkg::DEF_TASK_ID_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrts_pkg::dp_cmd_t             cmd,
  output rrts_pkg::dp_stat_t            stat,
  input  logic [rrts_pkg::ACTION_W-1:0] action,
  input  logic [rrts_pkg::CPU_W-1:0]    cpu,
  input  logic [TASK_ID_WIDTH-1:0]      task_id,
  output logic                          done,
  output logic [rrts_pkg::STATUS_W-1:0] status,
  output logic [TASK_ID_WIDTH-1:0]      picked_task
);
  import rrts_pkg::*;

  localparam int AW     = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int BIT_W  = $clog2(CNT_W);
  localparam int CIDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int OWN_W  = CPU_W + 1;

  // pool store: id and {owned, owner}
  logic [TASK_ID_WIDTH-1:0] id_mem  [MAX_TASKS];
  logic [OWN_W-1:0]         own_mem [MAX_TASKS];
  logic [TASK_ID_WIDTH-1:0] rd_id;
  logic [OWN_W-1:0]         rd_own;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [TASK_ID_WIDTH-1:0] wr_id;
  logic [OWN_W-1:0]         wr_own;

  logic [CNT_W-1:0]         count;
  logic [AW-1:0]            last_pick;
  logic [AW-1:0]            last_addr;

  action_t                  act_q;
  logic [CPU_W-1:0]         cpu_q;
  logic [TASK_ID_WIDTH-1:0] id_q;
  logic [CIDX_W-1:0]        cidx;

  logic                     cur_valid  [NUM_CPUS];
  logic [TASK_ID_WIDTH-1:0] cur_id     [NUM_CPUS];
  logic                     prev_valid [NUM_CPUS];
  logic [TASK_ID_WIDTH-1:0] prev_id    [NUM_CPUS];

  logic [CNT_W-1:0]         mod_r;
  logic [BIT_W-1:0]         bit_idx;
  logic [CNT_W-1:0]         num;
  logic [CNT_W:0]           trial;
  logic [CNT_W-1:0]         mod_r_next;

  logic [AW-1:0]            ptr;
  logic [AW-1:0]            ptr_next;
  logic [AW-1:0]            scan_first;
  logic [CNT_W-1:0]         remaining;
  logic                     pend;
  logic [AW-1:0]            pend_addr;
  logic [AW-1:0]            hit_addr;
  logic                     match;
  logic                     rd_owned;
  logic [CPU_W-1:0]         rd_owner;

  status_t                  status_q;
  logic [TASK_ID_WIDTH-1:0] picked_q;

  // ---------------- request latch ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action_t'(action);
      cpu_q <= cpu;
      id_q  <= task_id;
    end
  end

  assign cidx = CIDX_W'(cpu_q);

  // ---------------- pool memory ----------------
  assign last_addr = AW'(count - CNT_W'(1));
  assign rd_addr   = cmd.fetch_last ? last_addr : ptr;
  assign rd_owned  = rd_own[CPU_W];
  assign rd_owner  = rd_own[CPU_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_id   = rd_id;
    wr_own  = '0;
    if (cmd.append) begin
      wr_en   = 1'b1;
      wr_addr = AW'(count);
      wr_id   = id_q;
    end else if (cmd.claim) begin
      wr_en  = 1'b1;
      wr_own = {1'b1, cpu_q};
    end else if (cmd.free_own) begin
      wr_en = 1'b1;
    end else if (cmd.move) begin
      wr_en   = 1'b1;
      wr_addr = hit_addr;
      wr_own  = rd_own;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]  <= wr_id;
      own_mem[wr_addr] <= wr_own;
    end
    rd_id  <= id_mem[rd_addr];
    rd_own <= own_mem[rd_addr];
  end

  // ---------------- count and last pick ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      last_pick <= '0;
    end else begin
      if (cmd.append) begin
        count <= count + CNT_W'(1);
      end else if (cmd.move) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.claim) begin
        last_pick <= pend_addr;
      end
    end
  end

  // ---------------- per-CPU records ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CPUS; c++) begin
        cur_valid[c]  <= 1'b0;
        prev_valid[c] <= 1'b0;
      end
    end else if (cmd.claim || cmd.sched_idle) begin
      prev_valid[cidx] <= cur_valid[cidx];
      cur_valid[cidx]  <= cmd.claim;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.claim || cmd.sched_idle) begin
      prev_id[cidx] <= cur_id[cidx];
      cur_id[cidx]  <= cmd.claim ? rd_id : '0;
    end
  end

  // ---------------- start slot: (last_pick + 1) mod count, a bit a cycle ----
  assign num        = CNT_W'(last_pick) + CNT_W'(1);
  assign trial      = {mod_r, num[bit_idx]};
  assign mod_r_next = (trial >= {1'b0, count}) ? CNT_W'(trial - {1'b0, count})
                                               : trial[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      mod_r   <= '0;
      bit_idx <= BIT_W'(CNT_W - 1);
    end else if (cmd.mod_step) begin
      mod_r   <= mod_r_next;
      bit_idx <= bit_idx - BIT_W'(1);
    end
  end

  // ---------------- scan engine: one read issued per cycle ----------------
  assign scan_first = (act_q == ACT_SCHEDULE) ? AW'(mod_r) : '0;
  assign ptr_next   = ((CNT_W'(ptr) + CNT_W'(1)) == count) ? '0 : ptr + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.scan_start) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.scan_run && (remaining != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ptr       <= scan_first;
      remaining <= count;
    end else if (cmd.scan_run && (remaining != '0)) begin
      pend_addr <= ptr;
      ptr       <= ptr_next;
      remaining <= remaining - CNT_W'(1);
    end
    if (cmd.fetch_last) begin
      hit_addr <= pend_addr;
    end
  end

  always_comb begin
    case (act_q)
      ACT_TEARDOWN: match = (rd_id == id_q);
      ACT_SCHEDULE: match = !rd_owned;
      ACT_RELEASE:  match = rd_owned && (rd_owner == cpu_q) && (rd_id == prev_id[cidx]);
      default:      match = 1'b0;
    endcase
  end

  // ---------------- status to controller ----------------
  assign stat.act       = act_q;
  assign stat.full      = (count == CNT_W'(MAX_TASKS));
  assign stat.empty     = (count == '0);
  assign stat.cpu_ok    = (32'(cpu_q) < 32'(NUM_CPUS));
  assign stat.rel_skip  = !stat.cpu_ok || stat.empty || !prev_valid[cidx] ||
                          (cur_valid[cidx] && (cur_id[cidx] == prev_id[cidx]));
  assign stat.mod_last  = (bit_idx == '0);
  assign stat.hit       = pend && match;
  assign stat.exhausted = !pend && (remaining == '0);

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_q <= cmd.fin_status;
      picked_q <= cmd.fin_pick ? rd_id : '0;
    end
  end

  assign status      = status_q;
  assign picked_task = picked_q;

`ifndef SYNTHESIS
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (count < CNT_W'(MAX_TASKS)))
    else $error("append into a full pool");

  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    cmd.claim |-> (pend && !rd_owned))
    else $error("claim of an owned or unread entry");

  a_claim_pick: assert property (@(posedge clk) disable iff (rst)
    cmd.claim |=> (last_pick == $past(pend_addr)))
    else $error("last pick not updated by claim");
`endif

endmodule

>>> rtl/round_robin_task_pool_scheduler_top.sv
// Top level of the round-robin task pool scheduler.
`timescale 1ns / 1ps

// A request (action, cpu, task_id) transfers on a rising edge with start high and
// busy low; busy then stays high until the request has been handled. Exactly one
// result per request appears on status and picked_task for a single cycle with
// done high, and it cannot be stalled, so the receiver must take it then. One
// request is in work at a time. Create, a full-pool create, and a teardown, schedule
// or release that needs no search answer straight from the decode state. Teardown
// and release walk the pool through its single read port, one entry per cycle.
// Schedule first forms its start slot with a bit-serial remainder, then walks the
// pool the same way.
module round_robin_task_pool_scheduler_top #(
  parameter int MAX_TASKS     = rrts_pkg::DEF_MAX_TASKS,
  parameter int NUM_CPUS      = rrts_pkg::DEF_NUM_CPUS,
  parameter int TASK_ID_WIDTH = rrts_pkg::DEF_TASK_ID_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rrts_pkg::ACTION_W-1:0] action,
  input  logic [rrts_pkg::CPU_W-1:0]    cpu,
  input  logic [TASK_ID_WIDTH-1:0]      task_id,
  output logic                          done,
  output logic [rrts_pkg::STATUS_W-1:0] status,
  output logic [TASK_ID_WIDTH-1:0]      picked_task
);
  import rrts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rrts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rrts_datapath #(
    .MAX_TASKS     (MAX_TASKS),
    .NUM_CPUS      (NUM_CPUS),
    .TASK_ID_WIDTH (TASK_ID_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .cpu         (cpu),
    .task_id     (task_id),
    .done        (done),
    .status      (status),
    .picked_task (picked_task)
  );

endmodule
